// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk and disabled in reset.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk and disabled in reset.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/chtd_pkg.sv =====
// Package with the command kinds, fixed code lengths and table constants.
package chtd_pkg;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_FIXED  = 2'd1;
    localparam logic [1:0] KIND_DIRECT = 2'd2;
    localparam logic [1:0] KIND_EXACT  = 2'd3;

    localparam int LEN_SLOTS   = 16;
    localparam int FIXED_COUNT = 288;
    localparam int SYM_W       = 9;
    localparam int LEN_W       = 4;
    localparam int CODE_W      = 16;

    localparam logic [9:0] FIX_LAST_8A = 10'd143;
    localparam logic [9:0] FIX_LAST_9  = 10'd255;
    localparam logic [9:0] FIX_LAST_7  = 10'd279;
    localparam logic [9:0] FIX_LAST_8B = 10'd287;

    function automatic logic [3:0] fixed_len(input logic [9:0] sym);
        logic [3:0] len;
        if (sym <= FIX_LAST_8A) begin
            len = 4'd8;
        end else if (sym <= FIX_LAST_9) begin
            len = 4'd9;
        end else if (sym <= FIX_LAST_7) begin
            len = 4'd7;
        end else if (sym <= FIX_LAST_8B) begin
            len = 4'd8;
        end else begin
            len = 4'd0;
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/chtd_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module chtd_ram #(
    parameter int DEPTH = 288,
    parameter int WIDTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/canonical_huffman_table_decoder_top.sv =====
// Canonical Huffman decode table builder and lookup unit, top level.
// A command is transferred at a rising edge where i_start is high and o_busy is low.
// i_kind selects the command: load one length, load the fixed length set, look up a
// code in the direct table, or look up an exact code and length.
// A length load without i_last leaves the block ready for the next command.
// A length load with i_last, and a fixed load, start a table build that keeps o_busy
// high while it counts the loaded lengths, assigns the first code of each length,
// clears the direct table, fills the sorted-symbol table and writes the direct-table
// entries of each code no longer than the direct width; one symbol at a time.
// A lookup holds o_busy through one state for the table RAM read and one in which
// o_valid strobes the result, so the block takes no new command until that result
// has been shown.
// Each result is shown for one cycle only; the receiver cannot stall it.
// After reset the block clears the direct table with o_busy high, and then answers
// every lookup with a miss until tables are built.
`include "assert_macros.svh"

module canonical_huffman_table_decoder_top #(
    parameter int MAX_SYMBOLS   = 288,
    parameter int MAX_CODE_BITS = 15,
    parameter int DIRECT_BITS   = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_bit_length,
    input  logic        i_last,
    input  logic [14:0] i_code,
    input  logic [3:0]  i_code_len,
    output logic        o_valid,
    output logic        o_found,
    output logic [8:0]  o_symbol,
    output logic [3:0]  o_symbol_len
);

    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W  = $clog2(MAX_SYMBOLS);
    localparam int DSIZE  = 1 << DIRECT_BITS;
    localparam int JW     = 17 + DIRECT_BITS;
    localparam int ENT_W  = chtd_pkg::SYM_W + chtd_pkg::LEN_W;
    localparam int NFIXED = (MAX_SYMBOLS < chtd_pkg::FIXED_COUNT) ? MAX_SYMBOLS
                                                                  : chtd_pkg::FIXED_COUNT;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_CNT_RD   = 10'b00_0000_0010,
        ST_CNT_USE  = 10'b00_0000_0100,
        ST_CODES    = 10'b00_0000_1000,
        ST_CLEAR    = 10'b00_0001_0000,
        ST_FILL_RD  = 10'b00_0010_0000,
        ST_FILL_USE = 10'b00_0100_0000,
        ST_FILL_DWR = 10'b00_1000_0000,
        ST_LK_RD    = 10'b01_0000_0000,
        ST_LK_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_load_cnt, n_load_cnt;
    logic             r_fixed, n_fixed;
    logic [CNT_W-1:0] r_sym, n_sym;
    logic [3:0]       r_longest, n_longest;
    logic [3:0]       r_db, n_db;
    logic [3:0]       r_b, n_b;
    logic [15:0]      r_c, n_c;
    logic [CNT_W-1:0] r_sum, n_sum;
    logic [JW-1:0]    r_j, n_j;
    logic [JW-1:0]    r_end, n_end;
    logic [CNT_W-1:0] r_counts [chtd_pkg::LEN_SLOTS];
    logic [CNT_W-1:0] n_counts [chtd_pkg::LEN_SLOTS];
    logic [15:0]      r_first  [chtd_pkg::LEN_SLOTS];
    logic [15:0]      n_first  [chtd_pkg::LEN_SLOTS];
    logic [CNT_W-1:0] r_base   [chtd_pkg::LEN_SLOTS];
    logic [CNT_W-1:0] n_base   [chtd_pkg::LEN_SLOTS];
    logic [15:0]      r_next   [chtd_pkg::LEN_SLOTS];
    logic [15:0]      n_next   [chtd_pkg::LEN_SLOTS];
    logic [CNT_W-1:0] r_fill   [chtd_pkg::LEN_SLOTS];
    logic [CNT_W-1:0] n_fill   [chtd_pkg::LEN_SLOTS];
    logic                   r_is_exact, n_is_exact;
    logic                   r_hit, n_hit;
    logic [DIRECT_BITS-1:0] r_dt_addr, n_dt_addr;
    logic [IDX_W-1:0]       r_ss_addr, n_ss_addr;

    logic             w_accept;
    logic [3:0]       w_raw, w_len;
    logic [3:0]       w_sh;
    logic [15:0]      w_code;
    logic [JW-1:0]    w_start, w_endr, w_size, w_endc;
    logic [CNT_W:0]   w_sidx;
    logic [15:0]      w_c_sum;
    logic [DIRECT_BITS-1:0] w_dmask;
    logic [16:0]      w_off, w_xidx;
    logic             w_xhit;

    logic                   w_len_we;
    logic [3:0]             w_len_q;
    logic                   w_dt_we;
    logic [DIRECT_BITS-1:0] w_dt_waddr;
    logic [ENT_W-1:0]       w_dt_wdata, w_dt_q;
    logic                   w_ss_we;
    logic [IDX_W-1:0]       w_ss_waddr;
    logic [8:0]             w_ss_q;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign o_busy   = (r_state != ST_IDLE);

    assign w_raw = r_fixed ? chtd_pkg::fixed_len(10'(r_sym)) : w_len_q;
    assign w_len = (32'(w_raw) > MAX_CODE_BITS) ? 4'd0 : w_raw;

    assign w_code  = r_next[w_len];
    assign w_sh    = r_db - w_len;
    assign w_start = JW'(w_code) << w_sh;
    assign w_endr  = (JW'(w_code) + JW'(1)) << w_sh;
    assign w_size  = JW'(1) << r_db;
    assign w_endc  = (w_endr > w_size) ? w_size : w_endr;
    assign w_sidx  = (CNT_W+1)'(r_base[w_len]) + (CNT_W+1)'(r_fill[w_len]);

    assign w_c_sum = r_c + 16'(r_counts[r_b - 4'd1]);

    assign w_dmask = ~({DIRECT_BITS{1'b1}} << r_db);
    assign w_off   = {1'b0, 1'b0, i_code} - {1'b0, r_first[i_code_len]};
    assign w_xidx  = 17'(r_base[i_code_len]) + w_off;
    assign w_xhit  = (i_code_len != 4'd0) && (i_code_len <= r_longest) && !w_off[16]
                     && (w_off[15:0] < 16'(r_counts[i_code_len]))
                     && (32'(w_xidx) < MAX_SYMBOLS);

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_fixed    = r_fixed;
        n_sym      = r_sym;
        n_longest  = r_longest;
        n_db       = r_db;
        n_b        = r_b;
        n_c        = r_c;
        n_sum      = r_sum;
        n_j        = r_j;
        n_end      = r_end;
        n_counts   = r_counts;
        n_first    = r_first;
        n_base     = r_base;
        n_next     = r_next;
        n_fill     = r_fill;
        n_is_exact = r_is_exact;
        n_hit      = r_hit;
        n_dt_addr  = r_dt_addr;
        n_ss_addr  = r_ss_addr;
        w_len_we   = 1'b0;
        w_dt_we    = 1'b0;
        w_dt_waddr = r_j[DIRECT_BITS-1:0];
        w_dt_wdata = '0;
        w_ss_we    = 1'b0;
        w_ss_waddr = w_sidx[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        chtd_pkg::KIND_LOAD: begin
                            if (32'(r_load_cnt) < MAX_SYMBOLS) begin
                                w_len_we   = 1'b1;
                                n_load_cnt = r_load_cnt + CNT_W'(1);
                            end
                            n_fixed = 1'b0;
                            if (i_last) begin
                                n_state = ST_CNT_RD;
                            end
                        end
                        chtd_pkg::KIND_FIXED: begin
                            n_load_cnt = CNT_W'(NFIXED);
                            n_fixed    = 1'b1;
                            n_state    = ST_CNT_RD;
                        end
                        default: begin
                            n_is_exact = (i_kind == chtd_pkg::KIND_EXACT);
                            n_hit      = w_xhit;
                            n_dt_addr  = i_code[DIRECT_BITS-1:0] & w_dmask;
                            n_ss_addr  = w_xidx[IDX_W-1:0];
                            n_state    = ST_LK_RD;
                        end
                    endcase
                    n_sym     = '0;
                    n_longest = 4'd0;
                    for (int k = 0; k < chtd_pkg::LEN_SLOTS; k++) begin
                        n_fill[k] = '0;
                    end
                    if (i_kind == chtd_pkg::KIND_LOAD || i_kind == chtd_pkg::KIND_FIXED) begin
                        for (int k = 0; k < chtd_pkg::LEN_SLOTS; k++) begin
                            n_counts[k] = '0;
                        end
                    end
                    if (i_kind == chtd_pkg::KIND_LOAD && !i_last) begin
                        n_longest = r_longest;
                        n_counts  = r_counts;
                    end
                    if (i_kind[1]) begin
                        n_longest = r_longest;
                    end
                end
            end
            ST_CNT_RD: begin
                if (r_sym == r_load_cnt) begin
                    n_b      = 4'd1;
                    n_c      = '0;
                    n_sum    = '0;
                    n_first[0] = '0;
                    n_base[0]  = '0;
                    n_state  = ST_CODES;
                end else begin
                    n_state = ST_CNT_USE;
                end
            end
            ST_CNT_USE: begin
                if (w_len != 4'd0) begin
                    n_counts[w_len] = r_counts[w_len] + CNT_W'(1);
                    if (w_len > r_longest) begin
                        n_longest = w_len;
                    end
                end
                n_sym   = r_sym + CNT_W'(1);
                n_state = ST_CNT_RD;
            end
            ST_CODES: begin
                n_c            = {w_c_sum[14:0], 1'b0};
                n_first[r_b]   = {w_c_sum[14:0], 1'b0};
                n_next[r_b]    = {w_c_sum[14:0], 1'b0};
                n_base[r_b]    = r_sum;
                n_sum          = r_sum + r_counts[r_b];
                n_b            = r_b + 4'd1;
                if (r_b == 4'(chtd_pkg::LEN_SLOTS - 1)) begin
                    n_db    = (32'(r_longest) < DIRECT_BITS) ? r_longest : 4'(DIRECT_BITS);
                    n_j     = '0;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                w_dt_we = 1'b1;
                n_j     = r_j + JW'(1);
                if (r_j == JW'(DSIZE - 1)) begin
                    n_sym   = '0;
                    n_state = ST_FILL_RD;
                end
            end
            ST_FILL_RD: begin
                if (r_sym == r_load_cnt) begin
                    n_load_cnt = '0;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_FILL_USE;
                end
            end
            ST_FILL_USE: begin
                n_sym   = r_sym + CNT_W'(1);
                n_state = ST_FILL_RD;
                if (w_len != 4'd0) begin
                    n_next[w_len] = w_code + 16'd1;
                    n_fill[w_len] = r_fill[w_len] + CNT_W'(1);
                    w_ss_we       = (32'(w_sidx) < MAX_SYMBOLS);
                    if (w_len <= r_db && w_start < w_endc) begin
                        n_j     = w_start;
                        n_end   = w_endc;
                        n_sym   = r_sym;
                        n_state = ST_FILL_DWR;
                    end
                end
            end
            ST_FILL_DWR: begin
                w_dt_we    = 1'b1;
                w_dt_wdata = {w_len, 9'(r_sym)};
                n_j        = r_j + JW'(1);
                if (r_j + JW'(1) >= r_end) begin
                    n_sym   = r_sym + CNT_W'(1);
                    n_state = ST_FILL_RD;
                end
            end
            ST_LK_RD: begin
                n_state = ST_LK_OUT;
            end
            ST_LK_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_load_cnt <= '0;
            r_fixed    <= 1'b0;
            r_sym      <= '0;
            r_longest  <= 4'd0;
            r_db       <= 4'd0;
            r_b        <= 4'd0;
            r_c        <= '0;
            r_sum      <= '0;
            r_j        <= '0;
            r_end      <= '0;
            for (int k = 0; k < chtd_pkg::LEN_SLOTS; k++) begin
                r_counts[k] <= '0;
                r_first[k]  <= '0;
                r_base[k]   <= '0;
                r_next[k]   <= '0;
                r_fill[k]   <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_fixed    <= n_fixed;
            r_sym      <= n_sym;
            r_longest  <= n_longest;
            r_db       <= n_db;
            r_b        <= n_b;
            r_c        <= n_c;
            r_sum      <= n_sum;
            r_j        <= n_j;
            r_end      <= n_end;
            r_counts   <= n_counts;
            r_first    <= n_first;
            r_base     <= n_base;
            r_next     <= n_next;
            r_fill     <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_exact <= n_is_exact;
        r_hit      <= n_hit;
        r_dt_addr  <= n_dt_addr;
        r_ss_addr  <= n_ss_addr;
    end

    chtd_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(4)) u_lengths (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (r_load_cnt[IDX_W-1:0]),
        .i_wdata (i_bit_length),
        .i_raddr (r_sym[IDX_W-1:0]),
        .o_rdata (w_len_q)
    );

    chtd_ram #(.DEPTH(DSIZE), .WIDTH(ENT_W)) u_direct (
        .i_clk   (i_clk),
        .i_we    (w_dt_we),
        .i_waddr (w_dt_waddr),
        .i_wdata (w_dt_wdata),
        .i_raddr (r_dt_addr),
        .o_rdata (w_dt_q)
    );

    chtd_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(9)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (w_ss_we),
        .i_waddr (w_ss_waddr),
        .i_wdata (9'(r_sym)),
        .i_raddr (r_ss_addr),
        .o_rdata (w_ss_q)
    );

    always_comb begin
        o_valid      = (r_state == ST_LK_OUT);
        o_found      = 1'b0;
        o_symbol     = 9'd0;
        o_symbol_len = 4'd0;
        if (r_is_exact) begin
            if (r_hit) begin
                o_found  = 1'b1;
                o_symbol = w_ss_q;
            end
        end else if (w_dt_q[ENT_W-1:9] != 4'd0) begin
            o_found      = 1'b1;
            o_symbol     = w_dt_q[8:0];
            o_symbol_len = w_dt_q[ENT_W-1:9];
        end
    end

    `CHK_NEXT(a_strobe_single, o_valid, !o_valid)
    `CHK_NEXT(a_lookup_latency, i_start && !o_busy && i_kind[1], ##1 o_valid)
    `CHK_SAME(a_direct_width, r_state == ST_IDLE, 32'(r_db) <= DIRECT_BITS && r_db <= r_longest)
    `CHK_SAME(a_fill_range, r_state == ST_FILL_DWR, r_j < r_end && r_end <= w_size)

endmodule

// ===== tb/chtd_checker.sv =====
// Checker that predicts every lookup answer of the Huffman table decoder and compares it.
module chtd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_bit_length,
    input  logic        i_last,
    input  logic [14:0] i_code,
    input  logic [3:0]  i_code_len,
    input  logic        i_valid,
    input  logic        i_found,
    input  logic [8:0]  i_symbol,
    input  logic [3:0]  i_symbol_len,
    output int          o_errors,
    output int          o_pending,
    output int          o_builds,
    output int          o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM = 288;
    localparam int DBITS_MAX = 9;

    typedef struct packed {
        logic       found;
        logic [8:0] symbol;
        logic [3:0] symbol_len;
    } t_answer;

    logic [3:0]  sym_len [NSYM];
    logic [8:0]  len_count [chtd_pkg::LEN_SLOTS];
    logic [15:0] first_code [chtd_pkg::LEN_SLOTS];
    logic [8:0]  len_base [chtd_pkg::LEN_SLOTS];
    logic [12:0] direct_tab [1 << DBITS_MAX];
    logic [8:0]  sorted_sym [NSYM];
    logic [3:0]  longest;
    logic [3:0]  dbits;
    int          load_cnt;
    t_answer     answers_due [$];

    function automatic void build_tables();
        int n;
        int sum;
        int size;
        int idx;
        logic [15:0] c;
        logic [15:0] cd;
        logic [15:0] run_code [chtd_pkg::LEN_SLOTS];
        int fill [chtd_pkg::LEN_SLOTS];
        int l;
        int sh;
        longint j;
        longint stop;
        n = (load_cnt > NSYM) ? NSYM : load_cnt;
        longest = '0;
        for (int b = 0; b < chtd_pkg::LEN_SLOTS; b++) begin
            len_count[b] = '0;
            fill[b] = 0;
        end
        for (int s = 0; s < n; s++) begin
            l = int'(sym_len[s]);
            if (l != 0) begin
                len_count[l]++;
                if (l > longest) longest = 4'(l);
            end
        end
        c = '0;
        sum = 0;
        first_code[0] = '0;
        len_base[0] = '0;
        for (int b = 1; b < chtd_pkg::LEN_SLOTS; b++) begin
            c = 16'(16'(c + len_count[b-1]) << 1);
            first_code[b] = c;
            run_code[b] = c;
            len_base[b] = 9'(sum);
            sum += len_count[b];
        end
        dbits = (longest < DBITS_MAX) ? longest : 4'(DBITS_MAX);
        size = 1 << dbits;
        for (int k = 0; k < (1 << DBITS_MAX); k++) direct_tab[k] = '0;
        for (int s = 0; s < n; s++) begin
            l = int'(sym_len[s]);
            if (l != 0) begin
                cd = run_code[l];
                run_code[l] = cd + 16'd1;
                if (l <= dbits) begin
                    sh = dbits - l;
                    j = longint'(cd) << sh;
                    stop = (longint'(cd) + 1) << sh;
                    if (stop > size) stop = size;
                    for (; j < stop; j++) direct_tab[j] = {4'(l), 9'(s)};
                end
                idx = len_base[l] + fill[l];
                fill[l]++;
                if (idx < NSYM) sorted_sym[idx] = 9'(s);
            end
        end
        load_cnt = 0;
    endfunction

    function automatic t_answer lookup(input logic [1:0] kind, input logic [14:0] code,
                                       input logic [3:0] clen);
        t_answer a;
        logic [12:0] e;
        int off;
        int idx;
        a = '0;
        if (kind == chtd_pkg::KIND_DIRECT) begin
            e = direct_tab[code & ((15'd1 << dbits) - 15'd1)];
            if (e[12:9] != 0) begin
                a.found = 1'b1;
                a.symbol = e[8:0];
                a.symbol_len = e[12:9];
            end
        end else if (clen != 0 && clen <= longest && {1'b0, code} >= first_code[clen]) begin
            off = int'(code) - int'(first_code[clen]);
            if (off < len_count[clen]) begin
                idx = len_base[clen] + off;
                if (idx < NSYM) begin
                    a.found = 1'b1;
                    a.symbol = sorted_sym[idx];
                end
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int s = 0; s < NSYM; s++) sym_len[s] = '0;
            for (int b = 0; b < chtd_pkg::LEN_SLOTS; b++) begin
                len_count[b] = '0;
                first_code[b] = '0;
                len_base[b] = '0;
            end
            for (int k = 0; k < (1 << DBITS_MAX); k++) direct_tab[k] = '0;
            longest = '0;
            dbits = '0;
            load_cnt = 0;
            o_errors = 0;
            o_builds = 0;
            o_hits = 0;
            answers_due.delete();
        end else begin
            if (i_valid) begin
                got = '{i_found, i_symbol, i_symbol_len};
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %p", $time, got);
                    o_errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.found) o_hits++;
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0d, actual %0d",
                                 $time, want.found, got.found);
                        o_errors++;
                    end
                    if (got.symbol !== want.symbol) begin
                        $display("%0t: symbol mismatch: expected %0d, actual %0d",
                                 $time, want.symbol, got.symbol);
                        o_errors++;
                    end
                    if (got.symbol_len !== want.symbol_len) begin
                        $display("%0t: symbol_len mismatch: expected %0d, actual %0d",
                                 $time, want.symbol_len, got.symbol_len);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_kind)
                    chtd_pkg::KIND_LOAD: begin
                        if (load_cnt < NSYM) begin
                            sym_len[load_cnt] = i_bit_length;
                            load_cnt++;
                        end
                        if (i_last) begin
                            build_tables();
                            o_builds++;
                        end
                    end
                    chtd_pkg::KIND_FIXED: begin
                        for (int s = 0; s < NSYM; s++) sym_len[s] = chtd_pkg::fixed_len(10'(s));
                        load_cnt = NSYM;
                        build_tables();
                        o_builds++;
                    end
                    default: begin
                        answers_due.push_back(lookup(i_kind, i_code, i_code_len));
                    end
                endcase
            end
        end
        o_pending = answers_due.size();
    end
endmodule

// ===== tb/tb_canonical_huffman_table_decoder_top.sv =====
// Testbench top that drives commands into the Huffman table decoder and reports the verdict.
module tb_canonical_huffman_table_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS = 1450;
    localparam int LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_kind;
    logic [3:0]  i_bit_length;
    logic        i_last;
    logic [14:0] i_code;
    logic [3:0]  i_code_len;
    logic        o_valid;
    logic        o_found;
    logic [8:0]  o_symbol;
    logic [3:0]  o_symbol_len;
    int          errors;
    int          pending;
    int          builds;
    int          hits;
    int          cycles;
    int          sent;
    int          lookups;
    bit          no_gaps;

    canonical_huffman_table_decoder_top uut (.*);

    chtd_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_bit_length, .i_last,
        .i_code, .i_code_len, .i_valid(o_valid), .i_found(o_found), .i_symbol(o_symbol),
        .i_symbol_len(o_symbol_len), .o_errors(errors), .o_pending(pending),
        .o_builds(builds), .o_hits(hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send(input logic [1:0] kind, input logic [3:0] blen, input logic lst,
                        input logic [14:0] code, input logic [3:0] clen);
        int gap;
        i_start <= 1'b1;
        i_kind <= kind;
        i_bit_length <= blen;
        i_last <= lst;
        i_code <= code;
        i_code_len <= clen;
        do @(posedge i_clk); while (o_busy);
        sent++;
        if (kind == chtd_pkg::KIND_DIRECT || kind == chtd_pkg::KIND_EXACT) lookups++;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic lookup_rand(input logic [1:0] kind);
        logic [3:0] clen;
        logic [14:0] code;
        clen = 4'($urandom_range(0, 15));
        code = 15'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            clen = 4'($urandom_range(1, 9));
            code = 15'($urandom_range(0, (1 << clen) - 1));
        end
        send(kind, 4'($urandom), 1'($urandom), code, clen);
    endtask

    // Lengths are drawn so that the set never over-subscribes the code space.
    task automatic load_set(input int count, input int max_len);
        int budget;
        int l;
        int w;
        budget = 1 << 15;
        for (int s = 0; s < count; s++) begin
            l = $urandom_range(0, max_len);
            w = (l == 0) ? 0 : (1 << (15 - l));
            if (w > budget) begin
                l = 0;
                w = 0;
            end
            budget -= w;
            send(chtd_pkg::KIND_LOAD, 4'(l), s == count - 1, 15'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        int r;
        int cnt;
        sent = 0;
        lookups = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind = chtd_pkg::KIND_LOAD;
        i_bit_length = '0;
        i_last = 1'b0;
        i_code = '0;
        i_code_len = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(chtd_pkg::KIND_DIRECT, 4'd0, 1'b0, 15'h7fff, 4'd15);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd0, 4'd1);
        send(chtd_pkg::KIND_LOAD, 4'd0, 1'b1, 15'd0, 4'd0);
        send(chtd_pkg::KIND_DIRECT, 4'd0, 1'b0, 15'd0, 4'd0);
        send(chtd_pkg::KIND_FIXED, 4'd15, 1'b1, 15'h7fff, 4'd15);
        send(chtd_pkg::KIND_DIRECT, 4'd0, 1'b0, 15'd0, 4'd0);
        send(chtd_pkg::KIND_DIRECT, 4'd0, 1'b0, 15'h7fff, 4'd0);
        send(chtd_pkg::KIND_DIRECT, 4'd0, 1'b0, 15'h0180, 4'd0);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd0, 4'd7);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd23, 4'd7);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd48, 4'd8);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd511, 4'd9);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd47, 4'd8);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd0, 4'd0);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'h7fff, 4'd15);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd10, 4'd10);
        send(chtd_pkg::KIND_LOAD, 4'd1, 1'b0, 15'd0, 4'd0);
        send(chtd_pkg::KIND_LOAD, 4'd15, 1'b1, 15'd0, 4'd0);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd0, 4'd1);
        send(chtd_pkg::KIND_EXACT, 4'd0, 1'b0, 15'd2, 4'd15);
        send(chtd_pkg::KIND_DIRECT, 4'd0, 1'b0, 15'h7e00, 4'd0);
        send(chtd_pkg::KIND_DIRECT, 4'd0, 1'b0, 15'h01ff, 4'd0);

        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        load_set(290, 15);
        repeat (20) lookup_rand(2'($urandom_range(2, 3)));

        while (sent < ITEMS) begin
            if (sent % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 6) begin
                load_set($urandom_range(1, 24), $urandom_range(1, 15));
            end else if (r < 7) begin
                cnt = $urandom_range(100, 288);
                if (cnt > ITEMS - sent) cnt = ITEMS - sent;
                load_set(cnt, $urandom_range(6, 15));
            end else if (r < 9) begin
                send(chtd_pkg::KIND_FIXED, 4'($urandom), 1'($urandom), 15'($urandom),
                     4'($urandom));
            end else if (r < 11) begin
                send(chtd_pkg::KIND_LOAD, 4'd0, 1'b0, 15'($urandom), 4'($urandom));
            end else begin
                lookup_rand(2'($urandom_range(2, 3)));
            end
        end

        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_busy);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d commands: %0d lookups, %0d hits, %0d table builds.",
                 sent, lookups, hits, builds);
        $display("Covered random, fixed and overlong length sets with direct and exact lookups.");
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
